// File: hw/rtl/tsa_pkg.sv
// Shared types and constants of the two-level slot allocator.
// Depends on nothing; used by tsa_ctrl, tsa_dp and two_level_slot_allocator.
package tsa_pkg;

	// Bitmap word geometry: one memory word covers this many slots
	localparam int WORD_BITS = 64;
	localparam int BIT_W     = 6;

	// Request modes
	typedef logic [2:0] mode_t;
	localparam mode_t MODE_ALLOC_G = 3'd0;
	localparam mode_t MODE_ALLOC_O = 3'd1;
	localparam mode_t MODE_FREE_G  = 3'd2;
	localparam mode_t MODE_FREE_O  = 3'd3;
	localparam mode_t MODE_QUERY_G = 3'd4;
	localparam mode_t MODE_QUERY_O = 3'd5;

	// Response status codes
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		mode_t      mode;
		logic [8:0] owner;
		logic [9:0] slot;
	} req_t;

	typedef struct packed {
		logic [9:0] granted_slot;
		logic       status;
		logic       slot_in_use;
	} rsp_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic clr_step;
		logic scan_start;
		logic scan_step;
		logic hit_take;
		logic grant_wr;
		logic cnt_inc;
		logic single_rd;
		logic single_upd;
		logic set_full;
		logic resp_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic  clr_last;
		logic  scan_hit;
		logic  scan_end;
		mode_t mode;
		logic  slot_ok;
		logic  owner_ok;
	} sts_t;

endpackage

// File: hw/rtl/tsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module tsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/tsa_ctrl.sv
// Controller state machine of the slot allocator: sequences clear, scan and update steps.
// Depends on tsa_pkg.
module tsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  tsa_pkg::sts_t sts,
	output tsa_pkg::cmd_t cmd
);

	typedef enum logic [8:0] {
		S_CLEAR    = 9'b000000001,
		S_IDLE     = 9'b000000010,
		S_DISPATCH = 9'b000000100,
		S_SCAN     = 9'b000001000,
		S_GRANT    = 9'b000010000,
		S_COUNT    = 9'b000100000,
		S_READ     = 9'b001000000,
		S_UPDATE   = 9'b010000000,
		S_RESP     = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.mode)
					tsa_pkg::MODE_ALLOC_G: begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
					tsa_pkg::MODE_ALLOC_O: begin
						if (sts.owner_ok) begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end else begin
							cmd.set_full = 1'b1;
							state_d      = S_RESP;
						end
					end
					tsa_pkg::MODE_FREE_G, tsa_pkg::MODE_FREE_O,
					tsa_pkg::MODE_QUERY_G, tsa_pkg::MODE_QUERY_O: begin
						state_d = sts.slot_ok ? S_READ : S_RESP;
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_hit) begin
					cmd.hit_take = 1'b1;
					state_d      = S_GRANT;
				end else if (sts.scan_end) begin
					cmd.set_full = 1'b1;
					state_d      = S_RESP;
				end
			end
			S_GRANT: begin
				cmd.grant_wr = 1'b1;
				state_d      = (sts.mode == tsa_pkg::MODE_ALLOC_O) ? S_COUNT : S_RESP;
			end
			S_COUNT: begin
				cmd.cnt_inc = 1'b1;
				state_d     = S_RESP;
			end
			S_READ: begin
				cmd.single_rd = 1'b1;
				state_d       = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.single_upd = 1'b1;
				state_d        = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.resp_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.resp_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

	a_resp_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp_load |-> (!out_valid_q || rsp_ready))
		else $error("response loaded over an untaken result");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !out_valid_q)
		else $error("result pending during clearing pass");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

endmodule

// File: hw/rtl/tsa_dp.sv
// Datapath of the slot allocator: bitmap memories, holder counts, scan and result registers.
// Depends on tsa_pkg and tsa_ram.
module tsa_dp #(
	parameter int SLOTS  = 1024,
	parameter int OWNERS = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tsa_pkg::req_t req,
	input  tsa_pkg::cmd_t cmd,
	output tsa_pkg::sts_t sts,
	output tsa_pkg::rsp_t rsp
);

	localparam int W       = tsa_pkg::WORD_BITS;
	localparam int BW      = tsa_pkg::BIT_W;
	localparam int GWORDS  = (SLOTS + W - 1) / W;
	localparam int GAW     = (GWORDS > 1) ? $clog2(GWORDS) : 1;
	localparam int IW      = GAW + BW;
	localparam int CDEPTH  = 2 ** IW;
	localparam int ODEPTH  = OWNERS * GWORDS;
	localparam int OAW     = (ODEPTH > 1) ? $clog2(ODEPTH) : 1;
	localparam int CW      = $clog2(OWNERS + 1);
	localparam int CLR_LEN = (ODEPTH > CDEPTH) ? ODEPTH : CDEPTH;
	localparam int CLW     = $clog2(CLR_LEN);
	localparam int TAIL    = SLOTS % W;
	localparam logic [W-1:0] LAST_MASK = (TAIL == 0) ? {W{1'b1}} : ((W'(1) << TAIL) - W'(1));

	// Lowest set bit of a bitmap word
	function automatic logic [BW-1:0] first_set(input logic [W-1:0] v);
		logic [BW-1:0] idx;
		idx = '0;
		for (int i = W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = BW'(i);
			end
		end
		return idx;
	endfunction

	// Request registers
	tsa_pkg::mode_t mode_q;
	logic           slot_ok_q;
	logic           owner_ok_q;
	logic [OAW-1:0] base_q;
	logic [GAW-1:0] sword_q;
	logic [BW-1:0]  sbit_q;
	logic [IW-1:0]  sidx_q;
	logic [31:0]    base_full;
	logic [31:0]    slot_full;

	// Scan and clear registers
	logic [CLW-1:0] clr_q;
	logic [GAW:0]   wcnt_q;
	logic           pend_s1;
	logic [GAW-1:0] eword_s1;
	logic [GAW-1:0] hit_word_q;
	logic [BW-1:0]  hit_bit_q;
	logic [2*W-1:0] gword_q;
	logic [W-1:0]   oword_q;
	tsa_pkg::rsp_t  res_q;
	tsa_pkg::rsp_t  rsp_q;

	// Memory ports
	logic           g_we;
	logic [GAW-1:0] g_waddr;
	logic [2*W-1:0] g_wdata;
	logic [GAW-1:0] g_raddr;
	logic [2*W-1:0] g_rdata;
	logic           o_we;
	logic [OAW-1:0] o_waddr;
	logic [W-1:0]   o_wdata;
	logic [OAW-1:0] o_raddr;
	logic [W-1:0]   o_rdata;
	logic           c_we;
	logic [IW-1:0]  c_waddr;
	logic [CW-1:0]  c_wdata;
	logic [IW-1:0]  c_raddr;
	logic [CW-1:0]  c_rdata;

	// Scan and update logic
	logic           scan_end;
	logic           scan_issue;
	logic [W-1:0]   g_used;
	logic [W-1:0]   g_shared;
	logic [W-1:0]   word_mask;
	logic [W-1:0]   free_vec;
	logic [BW-1:0]  hit_bit;
	logic [31:0]    gidx_full;
	logic [IW-1:0]  hit_idx;
	logic [W-1:0]   hot;
	logic [W-1:0]   shot;
	logic           held;
	logic [CW-1:0]  cnt_new;

	assign base_full = 32'(req.owner) * 32'(GWORDS);
	assign slot_full = 32'(req.slot);

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q     <= req.mode;
			slot_ok_q  <= slot_full < 32'(SLOTS);
			owner_ok_q <= 32'(req.owner) < 32'(OWNERS);
			base_q     <= base_full[OAW-1:0];
			sidx_q     <= slot_full[IW-1:0];
			sword_q    <= slot_full[IW-1:BW];
			sbit_q     <= slot_full[BW-1:0];
		end
	end

	// Word-level decode of the scanned word
	assign scan_end   = (wcnt_q == (GAW+1)'(GWORDS));
	assign scan_issue = cmd.scan_step && !scan_end;
	assign g_used     = g_rdata[W-1:0];
	assign g_shared   = g_rdata[2*W-1:W];

	always_comb begin
		word_mask = {W{1'b1}};
		if (eword_s1 == GAW'(GWORDS - 1)) begin
			word_mask = word_mask & LAST_MASK;
		end
		if (eword_s1 == '0) begin
			word_mask = word_mask & ~W'(1);
		end
	end

	assign free_vec  = ~g_used & word_mask &
		((mode_q == tsa_pkg::MODE_ALLOC_O) ? ~o_rdata : ~g_shared);
	assign hit_bit   = first_set(free_vec);
	assign gidx_full = 32'({eword_s1, hit_bit});
	assign hit_idx   = {hit_word_q, hit_bit_q};
	assign hot       = W'(1) << hit_bit_q;
	assign shot      = W'(1) << sbit_q;
	assign held      = owner_ok_q && (|(o_rdata & shot));
	assign cnt_new   = c_rdata - CW'(held);

	// Read addresses
	assign g_raddr = cmd.scan_step ? wcnt_q[GAW-1:0] : sword_q;
	assign o_raddr = base_q + OAW'(g_raddr);
	assign c_raddr = cmd.single_rd ? sidx_q : hit_idx;

	// Write ports: clearing pass, grant, count increment, free update
	always_comb begin
		g_we    = 1'b0;
		g_waddr = hit_word_q;
		g_wdata = gword_q;
		o_we    = 1'b0;
		o_waddr = base_q + OAW'(hit_word_q);
		o_wdata = oword_q | hot;
		c_we    = 1'b0;
		c_waddr = hit_idx;
		c_wdata = c_rdata + CW'(1);
		if (cmd.clr_step) begin
			g_we    = 32'(clr_q) < 32'(GWORDS);
			g_waddr = clr_q[GAW-1:0];
			g_wdata = '0;
			o_we    = 32'(clr_q) < 32'(ODEPTH);
			o_waddr = clr_q[OAW-1:0];
			o_wdata = '0;
			c_we    = 1'b1;
			c_waddr = clr_q[IW-1:0];
			c_wdata = '0;
		end else if (cmd.grant_wr) begin
			g_we = 1'b1;
			if (mode_q == tsa_pkg::MODE_ALLOC_O) begin
				g_wdata = {gword_q[2*W-1:W] | hot, gword_q[W-1:0]};
				o_we    = 1'b1;
			end else begin
				g_wdata = {gword_q[2*W-1:W] & ~hot, gword_q[W-1:0] | hot};
			end
		end else if (cmd.cnt_inc) begin
			c_we = 1'b1;
		end else if (cmd.single_upd) begin
			g_waddr = sword_q;
			o_waddr = base_q + OAW'(sword_q);
			o_wdata = o_rdata & ~shot;
			c_waddr = sidx_q;
			c_wdata = cnt_new;
			case (mode_q)
				tsa_pkg::MODE_FREE_G: begin
					g_we    = 1'b1;
					g_wdata = {g_shared, g_used & ~shot};
				end
				tsa_pkg::MODE_FREE_O: begin
					o_we    = owner_ok_q;
					c_we    = held;
					g_we    = (cnt_new == '0);
					g_wdata = {g_shared & ~shot, g_used};
				end
				default: begin
					g_we = 1'b0;
				end
			endcase
		end
	end

	// Control registers: clear sweep and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			wcnt_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + CLW'(1);
			end
			if (cmd.scan_start) begin
				wcnt_q <= '0;
			end else if (scan_issue) begin
				wcnt_q <= wcnt_q + (GAW+1)'(1);
			end
			pend_s1 <= scan_issue;
		end
	end

	// Scan tracking, hit capture and result assembly
	always_ff @(posedge clk) begin
		eword_s1 <= wcnt_q[GAW-1:0];
		if (cmd.hit_take) begin
			hit_word_q <= eword_s1;
			hit_bit_q  <= hit_bit;
			gword_q    <= g_rdata;
			oword_q    <= o_rdata;
		end
		if (cmd.load) begin
			res_q <= '0;
		end else begin
			if (cmd.set_full) begin
				res_q.status <= tsa_pkg::STATUS_FULL;
			end
			if (cmd.hit_take) begin
				res_q.granted_slot <= gidx_full[9:0];
			end
			if (cmd.single_upd && (mode_q == tsa_pkg::MODE_QUERY_G)) begin
				res_q.slot_in_use <= |(g_used & shot);
			end
			if (cmd.single_upd && (mode_q == tsa_pkg::MODE_QUERY_O)) begin
				res_q.slot_in_use <= owner_ok_q && (|(g_shared & shot)) && (|(o_rdata & shot));
			end
		end
		if (cmd.resp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp = rsp_q;

	assign sts.clr_last = (clr_q == CLW'(CLR_LEN - 1));
	assign sts.scan_hit = pend_s1 && (|free_vec);
	assign sts.scan_end = scan_end;
	assign sts.mode     = mode_q;
	assign sts.slot_ok  = slot_ok_q;
	assign sts.owner_ok = owner_ok_q;

	tsa_ram #(.WIDTH(2 * W), .DEPTH(GWORDS)) u_gmem (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	tsa_ram #(.WIDTH(W), .DEPTH(ODEPTH)) u_omem (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.raddr (o_raddr),
		.rdata (o_rdata)
	);

	tsa_ram #(.WIDTH(CW), .DEPTH(CDEPTH)) u_cmem (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit_take |-> (gidx_full != 32'd0) && (gidx_full < 32'(SLOTS)))
		else $error("scan hit outside the grantable range");

	a_cnt_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> (32'(c_rdata) < 32'(OWNERS)))
		else $error("holder count overflow");

	a_cnt_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.single_upd && (mode_q == tsa_pkg::MODE_FREE_O) && held) |-> (c_rdata != '0))
		else $error("holder count underflow");

endmodule

// File: hw/rtl/two_level_slot_allocator.sv
// Top level of the two-level slot allocator: controller plus datapath.
// Depends on tsa_pkg, tsa_ctrl, tsa_dp (and tsa_ram through tsa_dp).
//
//   channel   handshake                payload          direction
//   request   req_valid / req_ready    req   (req_t)    in
//   response  rsp_valid / rsp_ready    rsp   (rsp_t)    out
//
// Allocations scan the bitmap one 64-slot word per cycle, bounded by the single read port
// of the bitmap memory. Frees and queries read one bitmap word and its holder count;
// frees write the updated word back, and owner frees also update the holder count.
// After reset a clearing pass zeroes the memories; no request is taken meanwhile.
// A waiting response holds in its output register; the next request is taken meanwhile.
module two_level_slot_allocator #(
	parameter int SLOTS  = 1024,
	parameter int OWNERS = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  tsa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output tsa_pkg::rsp_t rsp
);

	tsa_pkg::cmd_t cmd;
	tsa_pkg::sts_t sts;

	tsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tsa_dp #(.SLOTS(SLOTS), .OWNERS(OWNERS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

// File: dv/two_level_slot_allocator_test.sv
// Self-checking testbench for two_level_slot_allocator: random and directed requests
// against a bit-exact predictor of the slot bitmaps. Depends on tsa_pkg and the RTL.
module two_level_slot_allocator_test;

	localparam int SLOTS  = 1024;
	localparam int OWNERS = 512;

	// Modes the block does not decode
	localparam tsa_pkg::mode_t MODE_RSVD_6 = 3'd6;
	localparam tsa_pkg::mode_t MODE_RSVD_7 = 3'd7;

	// Cycles for the long receiver hold and for the tail after the last response
	localparam int LONG_HOLD  = 400;
	localparam int TAIL_WAIT  = 40;
	localparam int RANDOM_CNT = 1725;

	// Slot bitmaps, per-slot holder counts and the queue of pending responses
	class slot_scoreboard;
		bit             global_used [SLOTS];
		bit             shared_flag [SLOTS];
		bit             owner_used  [OWNERS*SLOTS];
		int unsigned    holders     [SLOTS];
		int unsigned    top_granted;
		tsa_pkg::rsp_t  pending_rsp [$];
		int             errors;

		function int unsigned first_free_global();
			int unsigned i;
			for (i = 1; i < SLOTS; i++) begin
				if (!global_used[i] && !shared_flag[i])
					return i;
			end
			return 0;
		endfunction

		function int unsigned first_free_owner(int unsigned owner);
			int unsigned i;
			for (i = 1; i < SLOTS; i++) begin
				if (!global_used[i] && !owner_used[owner*SLOTS + i])
					return i;
			end
			return 0;
		endfunction

		function tsa_pkg::rsp_t predict(tsa_pkg::req_t r);
			tsa_pkg::rsp_t res;
			int unsigned   s;
			int unsigned   pos;
			bit            slot_ok;
			bit            owner_ok;
			res          = '0;
			res.status   = tsa_pkg::STATUS_DONE;
			slot_ok      = int'(r.slot) < SLOTS;
			owner_ok     = int'(r.owner) < OWNERS;
			pos          = int'(r.owner) * SLOTS + int'(r.slot);
			case (r.mode)
				tsa_pkg::MODE_ALLOC_G: begin
					s = first_free_global();
					if (s == 0) begin
						res.status = tsa_pkg::STATUS_FULL;
					end else begin
						global_used[s]   = 1'b1;
						shared_flag[s]   = 1'b0;
						res.granted_slot = 10'(s);
					end
				end
				tsa_pkg::MODE_ALLOC_O: begin
					s = owner_ok ? first_free_owner(r.owner) : 0;
					if (s == 0) begin
						res.status = tsa_pkg::STATUS_FULL;
					end else begin
						pos = int'(r.owner) * SLOTS + s;
						if (!owner_used[pos])
							holders[s]++;
						owner_used[pos]  = 1'b1;
						shared_flag[s]   = 1'b1;
						res.granted_slot = 10'(s);
					end
				end
				tsa_pkg::MODE_FREE_G: begin
					if (slot_ok)
						global_used[r.slot] = 1'b0;
				end
				tsa_pkg::MODE_FREE_O: begin
					// Drop the owner bit, then clear the shared flag once nobody holds the slot
					if (slot_ok) begin
						if (owner_ok && owner_used[pos]) begin
							owner_used[pos] = 1'b0;
							holders[r.slot]--;
						end
						if (holders[r.slot] == 0)
							shared_flag[r.slot] = 1'b0;
					end
				end
				tsa_pkg::MODE_QUERY_G: begin
					if (slot_ok)
						res.slot_in_use = global_used[r.slot];
				end
				tsa_pkg::MODE_QUERY_O: begin
					if (slot_ok && owner_ok && shared_flag[r.slot])
						res.slot_in_use = owner_used[pos];
				end
				default: ;
			endcase
			if (res.granted_slot > top_granted)
				top_granted = res.granted_slot;
			return res;
		endfunction

		function void note_request(tsa_pkg::req_t r);
			pending_rsp.push_back(predict(r));
		endfunction

		function void check_response(tsa_pkg::rsp_t act);
			tsa_pkg::rsp_t exp;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response %h", $time, act);
				errors++;
				return;
			end
			exp = pending_rsp.pop_front();
			if (act.granted_slot !== exp.granted_slot) begin
				$display("%0t: granted_slot expected %0d actual %0d",
					$time, exp.granted_slot, act.granted_slot);
				errors++;
			end
			if (act.status !== exp.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp.status, act.status);
				errors++;
			end
			if (act.slot_in_use !== exp.slot_in_use) begin
				$display("%0t: slot_in_use expected %0d actual %0d",
					$time, exp.slot_in_use, act.slot_in_use);
				errors++;
			end
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	tsa_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_ready;
	tsa_pkg::rsp_t rsp;

	slot_scoreboard sb = new();
	bit             idle_en;
	bit             long_hold_go;
	int             sent;

	two_level_slot_allocator #(
		.SLOTS (SLOTS),
		.OWNERS(OWNERS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #1 clk = ~clk;

	function tsa_pkg::req_t mk_req(tsa_pkg::mode_t mode, int owner, int slot);
		tsa_pkg::req_t r;
		r.mode  = mode;
		r.owner = 9'(owner);
		r.slot  = 10'(slot);
		return r;
	endfunction

	// Bias owners to a few and slots to the allocated region so ops hit live entries
	function tsa_pkg::req_t rand_req();
		int             w;
		int             owner;
		int             slot;
		int             hi;
		tsa_pkg::mode_t mode;
		w = $urandom_range(0, 99);
		if (w < 22)
			mode = tsa_pkg::MODE_ALLOC_G;
		else if (w < 44)
			mode = tsa_pkg::MODE_ALLOC_O;
		else if (w < 60)
			mode = tsa_pkg::MODE_FREE_G;
		else if (w < 76)
			mode = tsa_pkg::MODE_FREE_O;
		else if (w < 86)
			mode = tsa_pkg::MODE_QUERY_G;
		else if (w < 96)
			mode = tsa_pkg::MODE_QUERY_O;
		else
			mode = w[0] ? MODE_RSVD_7 : MODE_RSVD_6;
		owner = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, OWNERS - 1);
		hi    = (sb.top_granted + 1 < SLOTS) ? sb.top_granted + 1 : SLOTS - 1;
		slot  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, hi) : $urandom_range(0, SLOTS - 1);
		return mk_req(mode, owner, slot);
	endfunction

	// Offer one request, note it on transfer, then maybe leave a gap
	task automatic send_req(input tsa_pkg::req_t r);
		int gap;
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
		sent++;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lower valid and wait until every pending response has come back
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_rsp.size() != 0);
	endtask

	// Response side: check each transfer, stall in bursts or for one long hold
	initial begin : rsp_side
		int hold;
		hold = 0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
			if (long_hold_go) begin
				long_hold_go = 1'b0;
				hold         = LONG_HOLD;
			end
			if (hold > 0) begin
				hold--;
				rsp_ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 16) - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Request side and end of run
	initial begin : req_side
		int n;
		int o;
		int rand_start;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		idle_en      = 1'b1;
		long_hold_go = 1'b0;
		sent         = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pool, grants, shared slots, frees of unused slots, reserved modes
		send_req(mk_req(tsa_pkg::MODE_QUERY_G, 0, 0));
		send_req(mk_req(tsa_pkg::MODE_QUERY_G, 511, 1023));
		send_req(mk_req(tsa_pkg::MODE_ALLOC_G, 0, 0));
		send_req(mk_req(tsa_pkg::MODE_ALLOC_G, 511, 1023));
		send_req(mk_req(tsa_pkg::MODE_ALLOC_O, 0, 0));
		send_req(mk_req(tsa_pkg::MODE_ALLOC_O, 511, 1023));
		send_req(mk_req(tsa_pkg::MODE_QUERY_O, 0, 3));
		send_req(mk_req(tsa_pkg::MODE_QUERY_O, 511, 3));
		send_req(mk_req(tsa_pkg::MODE_QUERY_O, 5, 3));
		send_req(mk_req(tsa_pkg::MODE_ALLOC_G, 0, 0));
		send_req(mk_req(tsa_pkg::MODE_FREE_G, 0, 2));
		send_req(mk_req(tsa_pkg::MODE_ALLOC_G, 0, 0));
		send_req(mk_req(tsa_pkg::MODE_FREE_O, 0, 3));
		send_req(mk_req(tsa_pkg::MODE_QUERY_O, 511, 3));
		send_req(mk_req(tsa_pkg::MODE_ALLOC_G, 0, 0));
		send_req(mk_req(tsa_pkg::MODE_FREE_O, 511, 3));
		send_req(mk_req(tsa_pkg::MODE_ALLOC_G, 0, 0));
		send_req(mk_req(tsa_pkg::MODE_FREE_G, 0, 0));
		send_req(mk_req(tsa_pkg::MODE_FREE_G, 0, 1023));
		send_req(mk_req(tsa_pkg::MODE_FREE_O, 7, 1000));
		send_req(mk_req(tsa_pkg::MODE_QUERY_G, 0, 1));
		send_req(mk_req(MODE_RSVD_6, 511, 1023));
		send_req(mk_req(MODE_RSVD_7, 0, 0));
		send_req(mk_req(tsa_pkg::MODE_QUERY_O, 511, 1023));

		// Random mix, with one long receiver hold and one full drain
		rand_start = sent;
		for (int i = 0; i < 400; i++) begin
			if (i == 120)
				long_hold_go = 1'b1;
			if (i == 260)
				drain();
			send_req(rand_req());
		end

		// Fill the pool globally until it reports full, then run owners dry
		while (sb.first_free_global() != 0)
			send_req(mk_req(tsa_pkg::MODE_ALLOC_G, $urandom_range(0, OWNERS - 1),
				$urandom_range(0, SLOTS - 1)));
		repeat (4) send_req(mk_req(tsa_pkg::MODE_ALLOC_G, 0, 0));
		for (int k = 0; k < 2; k++) begin
			o = (k == 0) ? 0 : $urandom_range(1, OWNERS - 1);
			n = 0;
			while (sb.first_free_owner(o) != 0 && n < 1100) begin
				send_req(mk_req(tsa_pkg::MODE_ALLOC_O, o, $urandom_range(0, SLOTS - 1)));
				n++;
			end
			send_req(mk_req(tsa_pkg::MODE_ALLOC_O, o, 0));
		end

		// Random mix again; the final stretch runs without idling
		while (sent - rand_start < RANDOM_CNT) begin
			if (RANDOM_CNT - (sent - rand_start) < 200)
				idle_en = 1'b0;
			send_req(rand_req());
		end

		drain();
		repeat (TAIL_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.pending_rsp.size() == 0)
			$display("PASS two_level_slot_allocator");
		else
			$display("FAIL two_level_slot_allocator");
		$finish;
	end

	// Guard against a hung handshake
	initial begin : watchdog
		#1200000;
		$display("FAIL two_level_slot_allocator");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/tsa_pkg.sv
hw/rtl/tsa_ram.sv
hw/rtl/tsa_ctrl.sv
hw/rtl/tsa_dp.sv
hw/rtl/two_level_slot_allocator.sv
dv/two_level_slot_allocator_test.sv
